[rtl/core/drive_command_decoder_watchdog_core_macros.svh]
// assertion helpers for the drive command decoder rtl
`ifndef DRIVE_COMMAND_DECODER_WATCHDOG_CORE_MACROS_SVH
`define DRIVE_COMMAND_DECODER_WATCHDOG_CORE_MACROS_SVH

// property checked on every rising clock edge outside reset
`define DCDW_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition that must never hold outside reset
`define DCDW_ASSERT_NEVER(label, cond, msg) \
  `DCDW_ASSERT(label, !(cond), msg)

`endif

[rtl/core/dcdw_pkg.sv]
`default_nettype none

package dcdw_pkg;

  // default counter width of the watchdog
  localparam int unsigned TIMEOUT_BITS_DEF = 16;
  localparam int unsigned QUEUE_DEPTH      = 2;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WARN_LEVEL  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_FINE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_NORMAL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_ROUGH  = 3'd4;

  localparam logic [15:0] TIMEOUT_RST     = 16'd100;
  localparam logic [7:0]  WARN_LEVEL_RST  = 8'd120;
  localparam logic [7:0]  STEP_FINE_RST   = 8'd5;
  localparam logic [7:0]  STEP_NORMAL_RST = 8'd10;
  localparam logic [7:0]  STEP_ROUGH_RST  = 8'd20;
  localparam logic [7:0]  SPEED_RST       = 8'd255;
  localparam logic [7:0]  SPEED_CEIL      = 8'd255;

  // step modes
  localparam logic [1:0] MODE_FINE   = 2'd0;
  localparam logic [1:0] MODE_NORMAL = 2'd1;
  localparam logic [1:0] MODE_ROUGH  = 2'd2;

  // direction patterns
  localparam logic [7:0] PAT_STOP   = 8'd0;
  localparam logic [7:0] PAT_FWD    = 8'd216;
  localparam logic [7:0] PAT_BACK   = 8'd39;
  localparam logic [7:0] PAT_LEFT   = 8'd116;
  localparam logic [7:0] PAT_RIGHT  = 8'd139;
  localparam logic [7:0] PAT_SPIN_L = 8'd198;
  localparam logic [7:0] PAT_SPIN_R = 8'd57;

  // wheel masks: fl, fr, rl, rr from msb down
  localparam logic [3:0] WHEELS_ALL  = 4'b1111;
  localparam logic [3:0] WHEELS_FRRL = 4'b0110;
  localparam logic [3:0] WHEELS_FLRR = 4'b1001;

  // command bytes
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_F     = 8'h46;
  localparam logic [7:0] CH_J     = 8'h4A;
  localparam logic [7:0] CH_L     = 8'h4C;
  localparam logic [7:0] CH_N     = 8'h4E;
  localparam logic [7:0] CH_Q     = 8'h51;
  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_W     = 8'h57;
  localparam logic [7:0] CH_Z     = 8'h5A;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_TICK,
    OP_STOP,
    OP_MOVE,
    OP_PREFIX,
    OP_INC,
    OP_DEC,
    OP_FINE,
    OP_NORMAL,
    OP_ROUGH,
    OP_OTHER
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] pattern;
    logic [3:0] wheels;
  } cmd_t;

  typedef struct packed {
    logic       motor_valid;
    logic [7:0] dir_pattern;
    logic [7:0] duty_front_left;
    logic [7:0] duty_front_right;
    logic [7:0] duty_rear_left;
    logic [7:0] duty_rear_right;
    logic       gauge_valid;
    logic [7:0] speed_now;
    logic       speed_low;
    logic       step_changed;
    logic [1:0] step_mode;
    logic       watchdog_stop;
  } res_t;

endpackage

`default_nettype wire

[rtl/core/dcdw_fifo.sv]
`default_nettype none

module dcdw_fifo #(
  parameter type         T     = dcdw_pkg::cmd_t,
  parameter int unsigned Depth = dcdw_pkg::QUEUE_DEPTH
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire T     data_i,
  output logic      full_o,
  input  wire logic pop_i,
  output T          data_o,
  output logic      empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  T               mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d = wr_q;
    rd_d = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

[rtl/core/dcdw_front.sv]
`default_nettype none

module dcdw_front (
  input  wire logic       push_i,
  input  wire logic       action_i,
  input  wire logic [7:0] byte_value_i,
  output logic            full_o,
  input  wire logic       q_full_i,
  output logic            q_push_o,
  output dcdw_pkg::cmd_t  cmd_o
);

  assign full_o   = q_full_i;
  assign q_push_o = push_i;

  always_comb begin
    cmd_o.op      = dcdw_pkg::OP_OTHER;
    cmd_o.pattern = dcdw_pkg::PAT_STOP;
    cmd_o.wheels  = dcdw_pkg::WHEELS_ALL;
    if (action_i) begin
      cmd_o.op = dcdw_pkg::OP_TICK;
    end else begin
      case (byte_value_i)
        dcdw_pkg::CH_CR, dcdw_pkg::CH_LF: cmd_o.op = dcdw_pkg::OP_NONE;
        dcdw_pkg::CH_BANG:  cmd_o.op = dcdw_pkg::OP_STOP;
        dcdw_pkg::CH_PCT:   cmd_o.op = dcdw_pkg::OP_PREFIX;
        dcdw_pkg::CH_PLUS:  cmd_o.op = dcdw_pkg::OP_INC;
        dcdw_pkg::CH_MINUS: cmd_o.op = dcdw_pkg::OP_DEC;
        dcdw_pkg::CH_F:     cmd_o.op = dcdw_pkg::OP_FINE;
        dcdw_pkg::CH_N:     cmd_o.op = dcdw_pkg::OP_NORMAL;
        dcdw_pkg::CH_R:     cmd_o.op = dcdw_pkg::OP_ROUGH;
        dcdw_pkg::CH_W: begin
          cmd_o.op      = dcdw_pkg::OP_MOVE;
          cmd_o.pattern = dcdw_pkg::PAT_FWD;
        end
        dcdw_pkg::CH_S: begin
          cmd_o.op      = dcdw_pkg::OP_MOVE;
          cmd_o.pattern = dcdw_pkg::PAT_BACK;
        end
        dcdw_pkg::CH_A: begin
          cmd_o.op      = dcdw_pkg::OP_MOVE;
          cmd_o.pattern = dcdw_pkg::PAT_LEFT;
        end
        dcdw_pkg::CH_D: begin
          cmd_o.op      = dcdw_pkg::OP_MOVE;
          cmd_o.pattern = dcdw_pkg::PAT_RIGHT;
        end
        dcdw_pkg::CH_J: begin
          cmd_o.op      = dcdw_pkg::OP_MOVE;
          cmd_o.pattern = dcdw_pkg::PAT_SPIN_L;
        end
        dcdw_pkg::CH_L: begin
          cmd_o.op      = dcdw_pkg::OP_MOVE;
          cmd_o.pattern = dcdw_pkg::PAT_SPIN_R;
        end
        // diagonals drive one wheel pair only
        dcdw_pkg::CH_Q: begin
          cmd_o.op      = dcdw_pkg::OP_MOVE;
          cmd_o.pattern = dcdw_pkg::PAT_FWD;
          cmd_o.wheels  = dcdw_pkg::WHEELS_FRRL;
        end
        dcdw_pkg::CH_E: begin
          cmd_o.op      = dcdw_pkg::OP_MOVE;
          cmd_o.pattern = dcdw_pkg::PAT_FWD;
          cmd_o.wheels  = dcdw_pkg::WHEELS_FLRR;
        end
        dcdw_pkg::CH_Z: begin
          cmd_o.op      = dcdw_pkg::OP_MOVE;
          cmd_o.pattern = dcdw_pkg::PAT_BACK;
          cmd_o.wheels  = dcdw_pkg::WHEELS_FLRR;
        end
        dcdw_pkg::CH_C: begin
          cmd_o.op      = dcdw_pkg::OP_MOVE;
          cmd_o.pattern = dcdw_pkg::PAT_BACK;
          cmd_o.wheels  = dcdw_pkg::WHEELS_FRRL;
        end
        default: cmd_o.op = dcdw_pkg::OP_OTHER;
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/core/dcdw_back.sv]
`default_nettype none
`include "drive_command_decoder_watchdog_core_macros.svh"

module dcdw_back #(
  parameter int unsigned TimeoutBits = dcdw_pkg::TIMEOUT_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  input  wire logic [dcdw_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [dcdw_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire dcdw_pkg::cmd_t                cmd_i,
  input  wire logic                          cmd_empty_i,
  output logic                               cmd_pop_o,
  input  wire logic                          res_full_i,
  output logic                               res_push_o,
  output dcdw_pkg::res_t                     res_o
);

  localparam int unsigned CmpW = (TimeoutBits > 16) ? TimeoutBits : 16;

  logic [15:0]            timeout_q;
  logic [7:0]             warn_q, fine_q, normal_q, rough_q;
  logic [7:0]             speed_q, speed_d;
  logic [1:0]             mode_q, mode_d;
  logic                   prefix_q, prefix_d;
  logic                   armed_q, armed_d;
  logic [TimeoutBits-1:0] cnt_q, cnt_d;

  logic       fire, expire, wd_fire;
  logic [7:0] step, speed_inc, speed_dec;
  logic [8:0] sum;

  assign fire       = ~cmd_empty_i & ~res_full_i;
  assign cmd_pop_o  = fire;
  assign res_push_o = fire;
  assign wd_fire    = fire & res_o.watchdog_stop;

  // the counter stops at its maximum, which clips a larger timeout
  assign expire = (CmpW'(cnt_q) >= CmpW'(timeout_q)) || (&cnt_q);

  always_comb begin
    case (mode_q)
      dcdw_pkg::MODE_FINE:   step = fine_q;
      dcdw_pkg::MODE_NORMAL: step = normal_q;
      default:               step = rough_q;
    endcase
  end

  assign sum       = {1'b0, speed_q} + {1'b0, step};
  assign speed_inc = sum[8] ? dcdw_pkg::SPEED_CEIL : sum[7:0];
  assign speed_dec = (speed_q >= step) ? (speed_q - step) : 8'd0;

  always_comb begin
    speed_d  = speed_q;
    mode_d   = mode_q;
    prefix_d = prefix_q;
    armed_d  = armed_q;
    cnt_d    = cnt_q;
    res_o    = '0;
    case (cmd_i.op)
      dcdw_pkg::OP_TICK: begin
        if (armed_q) begin
          if (expire) begin
            res_o.motor_valid   = 1'b1;
            res_o.watchdog_stop = 1'b1;
            armed_d = 1'b0;
            cnt_d   = '0;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
      end
      dcdw_pkg::OP_STOP: begin
        res_o.motor_valid = 1'b1;
        armed_d  = 1'b0;
        cnt_d    = '0;
        prefix_d = 1'b0;
      end
      dcdw_pkg::OP_MOVE: begin
        res_o.motor_valid      = 1'b1;
        res_o.dir_pattern      = cmd_i.pattern;
        res_o.duty_front_left  = cmd_i.wheels[3] ? speed_q : 8'd0;
        res_o.duty_front_right = cmd_i.wheels[2] ? speed_q : 8'd0;
        res_o.duty_rear_left   = cmd_i.wheels[1] ? speed_q : 8'd0;
        res_o.duty_rear_right  = cmd_i.wheels[0] ? speed_q : 8'd0;
        prefix_d = 1'b0;
        armed_d  = 1'b1;
        cnt_d    = '0;
      end
      dcdw_pkg::OP_PREFIX: prefix_d = 1'b1;
      dcdw_pkg::OP_NONE: ;
      dcdw_pkg::OP_INC, dcdw_pkg::OP_DEC, dcdw_pkg::OP_FINE, dcdw_pkg::OP_NORMAL,
      dcdw_pkg::OP_ROUGH, dcdw_pkg::OP_OTHER: begin
        if (prefix_q) begin
          case (cmd_i.op)
            dcdw_pkg::OP_INC:    speed_d = speed_inc;
            dcdw_pkg::OP_DEC:    speed_d = speed_dec;
            dcdw_pkg::OP_FINE:   mode_d  = dcdw_pkg::MODE_FINE;
            dcdw_pkg::OP_NORMAL: mode_d  = dcdw_pkg::MODE_NORMAL;
            dcdw_pkg::OP_ROUGH:  mode_d  = dcdw_pkg::MODE_ROUGH;
            default: ;
          endcase
          prefix_d           = 1'b0;
          res_o.gauge_valid  = 1'b1;
          res_o.speed_now    = speed_d;
          res_o.speed_low    = (speed_d < warn_q);
          res_o.step_changed = (mode_d != mode_q);
          res_o.step_mode    = mode_d;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q  <= dcdw_pkg::SPEED_RST;
      mode_q   <= dcdw_pkg::MODE_NORMAL;
      prefix_q <= 1'b0;
      armed_q  <= 1'b0;
      cnt_q    <= '0;
    end else if (fire) begin
      speed_q  <= speed_d;
      mode_q   <= mode_d;
      prefix_q <= prefix_d;
      armed_q  <= armed_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= dcdw_pkg::TIMEOUT_RST;
      warn_q    <= dcdw_pkg::WARN_LEVEL_RST;
      fine_q    <= dcdw_pkg::STEP_FINE_RST;
      normal_q  <= dcdw_pkg::STEP_NORMAL_RST;
      rough_q   <= dcdw_pkg::STEP_ROUGH_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        dcdw_pkg::CFG_TIMEOUT:     timeout_q <= cfg_data_i;
        dcdw_pkg::CFG_WARN_LEVEL:  warn_q    <= cfg_data_i[7:0];
        dcdw_pkg::CFG_STEP_FINE:   fine_q    <= cfg_data_i[7:0];
        dcdw_pkg::CFG_STEP_NORMAL: normal_q  <= cfg_data_i[7:0];
        dcdw_pkg::CFG_STEP_ROUGH:  rough_q   <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  `DCDW_ASSERT_NEVER(a_one_kind, fire & res_o.motor_valid & res_o.gauge_valid, "mixed result")
  `DCDW_ASSERT(a_stop_is_zero, wd_fire |-> res_o.dir_pattern == dcdw_pkg::PAT_STOP, "stop pattern")
  `DCDW_ASSERT(a_stop_disarms, wd_fire |=> !armed_q, "watchdog still armed after timeout")
  `DCDW_ASSERT(a_idle_count, !armed_q |-> cnt_q == '0, "tick count runs while disarmed")
  `DCDW_ASSERT_NEVER(a_mode_range, mode_q == 2'd3, "step mode out of range")

endmodule

`default_nettype wire

[rtl/core/drive_command_decoder_watchdog_core.sv]
`default_nettype none

// Drive command decoder with watchdog. Command bytes and millisecond ticks enter
// through a queue-like port (push/full) and every accepted transaction yields
// exactly one result, read out in order through empty/pop. One transaction is
// taken per clock while the command queue is not full. An accepted transaction
// waits in the command queue behind the byte classifier; the execute stage,
// which holds speed, step mode, prefix and the watchdog counter, works it out
// combinationally and writes the result into the result queue at a clock edge
// when that queue is not full. Two-entry queues on both sides let the producer
// and the consumer stall independently. Configuration registers (index 0
// timeout, 1 warning level, 2..4 fine/normal/rough step) are always ready and
// should be written only while no transaction is in flight. No clearing pass
// after reset.
module drive_command_decoder_watchdog_core #(
  parameter int unsigned TimeoutBits = dcdw_pkg::TIMEOUT_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic                          action_i,
  input  wire logic [7:0]                    byte_value_i,
  output logic                               empty,
  input  wire logic                          pop,
  output logic                               motor_valid_o,
  output logic [7:0]                         dir_pattern_o,
  output logic [7:0]                         duty_front_left_o,
  output logic [7:0]                         duty_front_right_o,
  output logic [7:0]                         duty_rear_left_o,
  output logic [7:0]                         duty_rear_right_o,
  output logic                               gauge_valid_o,
  output logic [7:0]                         speed_now_o,
  output logic                               speed_low_o,
  output logic                               step_changed_o,
  output logic [1:0]                         step_mode_o,
  output logic                               watchdog_stop_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [dcdw_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [dcdw_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  dcdw_pkg::cmd_t cmd_in, cmd_out;
  dcdw_pkg::res_t res_in, res_out;
  logic           cmd_push, cmd_full, cmd_pop, cmd_empty;
  logic           res_push, res_full;

  assign cfg_ready_o = 1'b1;

  dcdw_front u_front (
    .push_i       (push),
    .action_i     (action_i),
    .byte_value_i (byte_value_i),
    .full_o       (full),
    .q_full_i     (cmd_full),
    .q_push_o     (cmd_push),
    .cmd_o        (cmd_in)
  );

  dcdw_fifo #(
    .T     (dcdw_pkg::cmd_t),
    .Depth (dcdw_pkg::QUEUE_DEPTH)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_out),
    .empty_o (cmd_empty)
  );

  dcdw_back #(
    .TimeoutBits (TimeoutBits)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd_out),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  dcdw_fifo #(
    .T     (dcdw_pkg::res_t),
    .Depth (dcdw_pkg::QUEUE_DEPTH)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_out),
    .empty_o (empty)
  );

  assign motor_valid_o      = res_out.motor_valid;
  assign dir_pattern_o      = res_out.dir_pattern;
  assign duty_front_left_o  = res_out.duty_front_left;
  assign duty_front_right_o = res_out.duty_front_right;
  assign duty_rear_left_o   = res_out.duty_rear_left;
  assign duty_rear_right_o  = res_out.duty_rear_right;
  assign gauge_valid_o      = res_out.gauge_valid;
  assign speed_now_o        = res_out.speed_now;
  assign speed_low_o        = res_out.speed_low;
  assign step_changed_o     = res_out.step_changed;
  assign step_mode_o        = res_out.step_mode;
  assign watchdog_stop_o    = res_out.watchdog_stop;

endmodule

`default_nettype wire

[verif/drive_check_pkg.sv]
package drive_check_pkg;
  import dcdw_pkg::*;

  class drive_scoreboard;
    // register copies
    logic [15:0] timeout_ticks;
    logic [7:0]  warn_level;
    logic [7:0]  inc_fine;
    logic [7:0]  inc_normal;
    logic [7:0]  inc_rough;

    // decoder state
    logic [7:0]  speed;
    logic [1:0]  mode;
    bit          prefix;
    bit          armed;
    logic [15:0] ticks;

    res_t        awaited_results[$];
    int unsigned errors;

    function new();
      timeout_ticks = TIMEOUT_RST;
      warn_level    = WARN_LEVEL_RST;
      inc_fine      = STEP_FINE_RST;
      inc_normal    = STEP_NORMAL_RST;
      inc_rough     = STEP_ROUGH_RST;
      speed         = SPEED_RST;
      mode          = MODE_NORMAL;
      prefix        = 1'b0;
      armed         = 1'b0;
      ticks         = '0;
      errors        = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_TIMEOUT:     timeout_ticks = data;
        CFG_WARN_LEVEL:  warn_level    = data[7:0];
        CFG_STEP_FINE:   inc_fine      = data[7:0];
        CFG_STEP_NORMAL: inc_normal    = data[7:0];
        CFG_STEP_ROUGH:  inc_rough     = data[7:0];
        default: ;
      endcase
    endfunction

    function logic [7:0] step_amt();
      case (mode)
        MODE_FINE:   return inc_fine;
        MODE_NORMAL: return inc_normal;
        default:     return inc_rough;
      endcase
    endfunction

    // works out the result of one accepted transaction
    function void predict_command(bit tick, logic [7:0] b);
      res_t       r;
      logic [7:0] pat;
      logic [3:0] wheels;
      logic [7:0] st;
      logic [8:0] sum;
      logic [1:0] old_mode;
      bit         mv;
      r = '0;
      if (tick) begin
        if (armed) begin
          if (ticks >= timeout_ticks) begin
            r.motor_valid   = 1'b1;
            r.watchdog_stop = 1'b1;
            armed = 1'b0;
            ticks = '0;
          end else begin
            ticks = ticks + 16'd1;
          end
        end
      end else if (b == CH_LF || b == CH_CR) begin
        // line endings leave everything alone, a pending prefix included
      end else if (b == CH_BANG) begin
        r.motor_valid = 1'b1;
        armed  = 1'b0;
        ticks  = '0;
        prefix = 1'b0;
      end else begin
        mv = 1'b1;
        wheels = WHEELS_ALL;
        case (b)
          CH_W: pat = PAT_FWD;
          CH_S: pat = PAT_BACK;
          CH_A: pat = PAT_LEFT;
          CH_D: pat = PAT_RIGHT;
          CH_J: pat = PAT_SPIN_L;
          CH_L: pat = PAT_SPIN_R;
          CH_Q: begin
            pat = PAT_FWD;
            wheels = WHEELS_FRRL;
          end
          CH_E: begin
            pat = PAT_FWD;
            wheels = WHEELS_FLRR;
          end
          CH_Z: begin
            pat = PAT_BACK;
            wheels = WHEELS_FLRR;
          end
          CH_C: begin
            pat = PAT_BACK;
            wheels = WHEELS_FRRL;
          end
          default: begin
            pat = PAT_STOP;
            mv = 1'b0;
          end
        endcase
        if (mv) begin
          r.motor_valid      = 1'b1;
          r.dir_pattern      = pat;
          r.duty_front_left  = wheels[3] ? speed : 8'd0;
          r.duty_front_right = wheels[2] ? speed : 8'd0;
          r.duty_rear_left   = wheels[1] ? speed : 8'd0;
          r.duty_rear_right  = wheels[0] ? speed : 8'd0;
          prefix = 1'b0;
          armed  = 1'b1;
          ticks  = '0;
        end else if (b == CH_PCT) begin
          prefix = 1'b1;
        end else if (prefix) begin
          old_mode = mode;
          st = step_amt();
          case (b)
            CH_PLUS: begin
              sum = {1'b0, speed} + {1'b0, st};
              speed = sum[8] ? SPEED_CEIL : sum[7:0];
            end
            CH_MINUS: speed = (speed >= st) ? speed - st : 8'd0;
            CH_R:     mode = MODE_ROUGH;
            CH_N:     mode = MODE_NORMAL;
            CH_F:     mode = MODE_FINE;
            default: ;
          endcase
          prefix = 1'b0;
          r.gauge_valid  = 1'b1;
          r.speed_now    = speed;
          r.speed_low    = speed < warn_level;
          r.step_changed = mode != old_mode;
          r.step_mode    = mode;
        end
      end
      awaited_results.push_back(r);
    endfunction

    function string show(res_t r);
      return $sformatf({"mv=%0d pat=%0d duty=%0d/%0d/%0d/%0d gv=%0d spd=%0d low=%0d",
                        " chg=%0d mode=%0d wd=%0d"},
                       r.motor_valid, r.dir_pattern, r.duty_front_left, r.duty_front_right,
                       r.duty_rear_left, r.duty_rear_right, r.gauge_valid, r.speed_now,
                       r.speed_low, r.step_changed, r.step_mode, r.watchdog_stop);
    endfunction

    function void flag_error(string msg);
      errors++;
      if (errors <= 10) begin
        $display("%s", msg);
      end
    endfunction

    function void check_result(res_t got);
      res_t  want;
      string diffs;
      if (awaited_results.size() == 0) begin
        flag_error($sformatf("result with no transaction outstanding: %s", show(got)));
        return;
      end
      want = awaited_results.pop_front();
      diffs = "";
      if (got.motor_valid      !== want.motor_valid)      diffs = {diffs, " motor_valid"};
      if (got.dir_pattern      !== want.dir_pattern)      diffs = {diffs, " dir_pattern"};
      if (got.duty_front_left  !== want.duty_front_left)  diffs = {diffs, " duty_front_left"};
      if (got.duty_front_right !== want.duty_front_right) diffs = {diffs, " duty_front_right"};
      if (got.duty_rear_left   !== want.duty_rear_left)   diffs = {diffs, " duty_rear_left"};
      if (got.duty_rear_right  !== want.duty_rear_right)  diffs = {diffs, " duty_rear_right"};
      if (got.gauge_valid      !== want.gauge_valid)      diffs = {diffs, " gauge_valid"};
      if (got.speed_now        !== want.speed_now)        diffs = {diffs, " speed_now"};
      if (got.speed_low        !== want.speed_low)        diffs = {diffs, " speed_low"};
      if (got.step_changed     !== want.step_changed)     diffs = {diffs, " step_changed"};
      if (got.step_mode        !== want.step_mode)        diffs = {diffs, " step_mode"};
      if (got.watchdog_stop    !== want.watchdog_stop)    diffs = {diffs, " watchdog_stop"};
      if (diffs != "") begin
        flag_error($sformatf("mismatch in%s\n  expected %s\n  actual   %s",
                             diffs, show(want), show(got)));
      end
    endfunction
  endclass

endpackage

[verif/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dcdw_pkg::*;
  import drive_check_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 500000;

  localparam logic [7:0] MOVE_KEYS [10] = '{CH_W, CH_S, CH_A, CH_D, CH_Q,
                                            CH_E, CH_Z, CH_C, CH_J, CH_L};
  localparam logic [7:0] SPEED_KEYS [5] = '{CH_PLUS, CH_MINUS, CH_F, CH_N, CH_R};

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  push = 1'b0;
  logic                  full;
  logic                  action_i = 1'b0;
  logic [7:0]            byte_value_i = 8'h00;
  logic                  empty;
  logic                  pop = 1'b0;
  logic                  motor_valid_o;
  logic [7:0]            dir_pattern_o;
  logic [7:0]            duty_front_left_o;
  logic [7:0]            duty_front_right_o;
  logic [7:0]            duty_rear_left_o;
  logic [7:0]            duty_rear_right_o;
  logic                  gauge_valid_o;
  logic [7:0]            speed_now_o;
  logic                  speed_low_o;
  logic                  step_changed_o;
  logic [1:0]            step_mode_o;
  logic                  watchdog_stop_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  res_t seen;
  assign seen = {motor_valid_o, dir_pattern_o, duty_front_left_o, duty_front_right_o,
                 duty_rear_left_o, duty_rear_right_o, gauge_valid_o, speed_now_o,
                 speed_low_o, step_changed_o, step_mode_o, watchdog_stop_o};

  drive_scoreboard sb = new();
  bit              src_steady = 1'b0;
  bit              sink_steady = 1'b0;
  int unsigned     items_sent = 0;

  drive_command_decoder_watchdog_core dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .push               (push),
    .full               (full),
    .action_i           (action_i),
    .byte_value_i       (byte_value_i),
    .empty              (empty),
    .pop                (pop),
    .motor_valid_o      (motor_valid_o),
    .dir_pattern_o      (dir_pattern_o),
    .duty_front_left_o  (duty_front_left_o),
    .duty_front_right_o (duty_front_right_o),
    .duty_rear_left_o   (duty_rear_left_o),
    .duty_rear_right_o  (duty_rear_right_o),
    .gauge_valid_o      (gauge_valid_o),
    .speed_now_o        (speed_now_o),
    .speed_low_o        (speed_low_o),
    .step_changed_o     (step_changed_o),
    .step_mode_o        (step_mode_o),
    .watchdog_stop_o    (watchdog_stop_o),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned gap_len(bit steady);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic push_item(bit tick, logic [7:0] b);
    int unsigned gap;
    gap = gap_len(src_steady);
    if ($urandom_range(0, 63) == 0) src_steady = ~src_steady;
    @(negedge clk_i);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    push         <= 1'b1;
    action_i     <= tick;
    byte_value_i <= b;
    do @(posedge clk_i); while (full);
    sb.predict_command(tick, b);
    items_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) begin
      push_item(1'b0, s[i]);
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_config(logic [15:0] tmo, logic [7:0] warn, logic [7:0] fine,
                            logic [7:0] normal, logic [7:0] rough);
    write_reg(CFG_TIMEOUT, tmo);
    write_reg(CFG_WARN_LEVEL, CFG_DATA_W'(warn));
    write_reg(CFG_STEP_FINE, CFG_DATA_W'(fine));
    write_reg(CFG_STEP_NORMAL, CFG_DATA_W'(normal));
    write_reg(CFG_STEP_ROUGH, CFG_DATA_W'(rough));
  endtask

  // stop pushing and wait until every result has drained
  task automatic settle();
    @(negedge clk_i);
    push <= 1'b0;
    while (sb.awaited_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic run_random(int unsigned count);
    int unsigned target;
    int unsigned r;
    int unsigned burst;
    target = items_sent + count;
    while (items_sent < target) begin
      r = $urandom_range(0, 99);
      if (r < 25) begin
        push_item(1'b0, MOVE_KEYS[$urandom_range(0, 9)]);
      end else if (r < 55) begin
        push_item(1'b0, CH_PCT);
        case ($urandom_range(0, 11))
          0: push_item(1'b0, CH_PCT);
          1: push_item(1'b0, CH_CR);
          2: push_item(1'b0, CH_LF);
          default: ;
        endcase
        if ($urandom_range(0, 7) == 0) push_item(1'b0, rand_byte());
        else push_item(1'b0, SPEED_KEYS[$urandom_range(0, 4)]);
      end else if (r < 75) begin
        // long bursts land around the timeout so the stop can fire
        if ($urandom_range(0, 4) != 0 || sb.timeout_ticks > 150) begin
          burst = $urandom_range(1, 4);
        end else begin
          burst = $urandom_range(sb.timeout_ticks, sb.timeout_ticks + 2);
        end
        repeat (burst) push_item(1'b1, rand_byte());
      end else if (r < 80) begin
        push_item(1'b0, CH_BANG);
      end else if (r < 92) begin
        push_item(1'b0, rand_byte());
      end else begin
        // prefix cut short by a movement or a stop
        push_item(1'b0, CH_PCT);
        push_item(1'b0, $urandom_range(0, 1) ? CH_BANG : MOVE_KEYS[$urandom_range(0, 9)]);
      end
    end
    settle();
  endtask

  initial begin : drain
    int unsigned hold;
    hold = 0;
    forever begin
      @(negedge clk_i);
      if (hold != 0) begin
        pop <= 1'b0;
        hold--;
      end else begin
        pop <= 1'b1;
        hold = gap_len(sink_steady);
        if ($urandom_range(0, 63) == 0) sink_steady = ~sink_steady;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      sb.check_result(seen);
    end
  end

  initial begin : cycle_guard
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings: every command but N, prefix corner cases, saturation at the top
    push_item(1'b1, 8'hFF);
    send_text("W%\n%+%F%-%");
    push_item(1'b0, 8'hFF);
    send_text("%Q+EZCASDJL!\r%R");
    settle();

    // short timeout, extreme warning level and steps
    set_config(16'd2, 8'd255, 8'd0, 8'd255, 8'd1);
    send_text("W");
    repeat (4) push_item(1'b1, rand_byte());
    send_text("%N%-%+C");
    push_item(1'b1, 8'h00);
    send_text("!");
    push_item(1'b1, 8'h00);
    settle();

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: set_config(16'd1, 8'd0, 8'd0, 8'd1, 8'd255);
        1: set_config(16'hFFFF, 8'd255, 8'd255, 8'd0, 8'd128);
        2: set_config(TIMEOUT_RST, WARN_LEVEL_RST, STEP_FINE_RST, STEP_NORMAL_RST,
                      STEP_ROUGH_RST);
        3: set_config(16'($urandom_range(1, 12)), rand_byte(), rand_byte(),
                      rand_byte(), rand_byte());
        default: set_config(16'($urandom_range(1, 300)), rand_byte(), rand_byte(),
                            rand_byte(), rand_byte());
      endcase
      run_random(150);
    end

    repeat (10) @(posedge clk_i);
    if (sb.errors == 0 && sb.awaited_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/dcdw_pkg.sv
rtl/core/dcdw_fifo.sv
rtl/core/dcdw_front.sv
rtl/core/dcdw_back.sv
rtl/core/drive_command_decoder_watchdog_core.sv
verif/drive_check_pkg.sv
verif/tb_top.sv
